// ----- hdl/rfps_pkg.sv -----
// ----------------------------------------------------------------------------
// rfps_pkg: shared types and constants of the rarest-first piece scheduler
// Holds the beat types, opcodes, action codes, the piece table entry layout
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfps_pkg;

   localparam int MAX_PIECES = 256;
   localparam int NUM_PEERS  = 8;

   localparam int PIECE_W    = $clog2(MAX_PIECES);
   localparam int PEER_W     = $clog2(NUM_PEERS);
   localparam int CNT_W      = $clog2(MAX_PIECES + 1);
   localparam int HOLD_W     = 8;
   localparam int RND_W      = 16;
   localparam int DIV_CNT_W  = $clog2(RND_W + 1);
   localparam int CSR_W      = 9;
   localparam int FLAG_W     = 4;

   // Opcodes of an input beat.
   localparam logic [2:0] OP_HAVE    = 3'd0;
   localparam logic [2:0] OP_CHOKE   = 3'd1;
   localparam logic [2:0] OP_UNCHOKE = 3'd2;
   localparam logic [2:0] OP_DONE    = 3'd3;
   localparam logic [2:0] OP_SELECT  = 3'd4;
   localparam logic [2:0] OP_OPEN    = 3'd5;
   localparam logic [2:0] OP_CLOSE   = 3'd6;
   // The unused opcode only closes the run with an end beat.
   localparam logic [2:0] OP_NOP     = 3'd7;

   // Actions of a result beat.
   localparam logic [1:0] ACT_END = 2'd0;
   localparam logic [1:0] ACT_INT = 2'd1;
   localparam logic [1:0] ACT_REQ = 2'd2;

   // Piece status codes.
   localparam logic [1:0] ST_NEW     = 2'd0;
   localparam logic [1:0] ST_LOADING = 2'd1;
   localparam logic [1:0] ST_DONE    = 2'd2;

   // Bit positions in the per-peer flags.
   localparam int F_OPEN     = 0;
   localparam int F_CHOKED   = 1;
   localparam int F_INTEREST = 2;
   localparam int F_BUSY     = 3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  peer;
      logic [7:0]  piece;
      logic [15:0] random_value;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] target_peer;
      logic [7:0] target_piece;
      logic       last;
   } rsp_type;

   // One piece table word: holder count, status and one holder bit per peer.
   typedef struct packed {
      logic [HOLD_W-1:0]    hold;
      logic [1:0]           status;
      logic [NUM_PEERS-1:0] has;
   } entry_type;

   typedef enum logic [2:0] {
      SCAN_INIT,
      SCAN_CLR,
      SCAN_MIN,
      SCAN_CNT,
      SCAN_PICK,
      SCAN_MORE
   } scan_mode_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_HAVE,
      WR_DONE,
      WR_LOAD
   } wr_sel_type;

   typedef struct packed {
      logic          accept;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          div_start;
      logic          rd_piece;
      wr_sel_type    wr_sel;
      logic          set_choke;
      logic          clr_choke;
      logic          set_int_req;
      logic          clr_int_req;
      logic          clr_busy_req;
      logic          peer_init;
      logic          peer_init_open;
      logic          ps_start;
      logic          ps_next;
      logic          ps_set_int;
      logic          ps_set_req;
      logic          emit;
      logic [1:0]    emit_action;
      logic          emit_scan_peer;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       scan_busy;
      logic       scan_found;
      logic       best_none;
      logic       div_busy;
      logic       out_free;
      logic       req_open;
      logic       req_int;
      logic       req_match;
      logic       piece_ok;
      logic       entry_new;
      logic       ps_end;
      logic       ps_cand;
      logic       ps_choked;
      logic       ps_int;
      logic       ps_busy;
   } sts_type;

endpackage

// ----- hdl/rfps_datapath.sv -----
// ----------------------------------------------------------------------------
// rfps_datapath: piece table, peer state, scan engine, divider, result stage
// Carries out the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module rfps_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  rfps_pkg::cmd_type               cmd,
   output rfps_pkg::sts_type               sts,
   input  rfps_pkg::req_type               req_data,
   input  logic                            csr_we,
   input  logic [rfps_pkg::CSR_W-1:0]      csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rfps_pkg::rsp_type               rsp_data
);

   rfps_pkg::req_type                    req_ff;
   logic [rfps_pkg::CSR_W-1:0]           csr_ff;
   logic [rfps_pkg::CNT_W-1:0]           n_eff;

   rfps_pkg::entry_type                  piece_mem_ff [rfps_pkg::MAX_PIECES];
   rfps_pkg::entry_type                  rdata_ff;
   logic                                 rd_en;
   logic [rfps_pkg::PIECE_W-1:0]         rd_addr;
   logic                                 wr_en;
   logic [rfps_pkg::PIECE_W-1:0]         wr_addr;
   rfps_pkg::entry_type                  wr_data;

   logic                                 active_ff;
   rfps_pkg::scan_mode_type              mode_ff;
   logic [rfps_pkg::CNT_W-1:0]           addr_ff;
   logic                                 vld_ff;
   logic [rfps_pkg::PIECE_W-1:0]         idx_ff;
   logic                                 found_ff;
   logic [rfps_pkg::HOLD_W:0]            best_ff;
   logic [rfps_pkg::CNT_W-1:0]           ties_ff;
   logic [rfps_pkg::CNT_W-1:0]           k_ff;
   logic [rfps_pkg::PIECE_W-1:0]         chosen_ff;
   rfps_pkg::entry_type                  chosen_e_ff;
   logic [rfps_pkg::CNT_W-1:0]           limit;
   logic                                 issue;
   logic                                 is_new;
   logic                                 is_tie;
   logic                                 found_now;

   logic [rfps_pkg::CNT_W-1:0]           rem_ff;
   logic [rfps_pkg::RND_W-1:0]           dvd_ff;
   logic [rfps_pkg::DIV_CNT_W-1:0]       dcnt_ff;
   logic [rfps_pkg::CNT_W:0]             trial;

   logic [rfps_pkg::FLAG_W-1:0]          flags_ff  [rfps_pkg::NUM_PEERS];
   logic [rfps_pkg::PIECE_W-1:0]         wanted_ff [rfps_pkg::NUM_PEERS];
   logic [rfps_pkg::PEER_W:0]            ps_ff;
   logic [rfps_pkg::PEER_W-1:0]          psi;
   logic [rfps_pkg::PEER_W-1:0]          rpi;

   logic                                 rsp_valid_ff;
   rfps_pkg::rsp_type                    rsp_data_ff;
   rfps_pkg::rsp_type                    rsp_data_in;

   localparam logic [rfps_pkg::HOLD_W:0] BEST_NONE = (rfps_pkg::HOLD_W + 1)'(1) <<
                                                     rfps_pkg::HOLD_W;
   localparam logic [rfps_pkg::HOLD_W-1:0] HOLD_SAT = '1;

   // Flag words of a freshly initialized slot: choking, not interested, idle.
   localparam logic [rfps_pkg::FLAG_W-1:0] FLAGS_CLOSED =
      rfps_pkg::FLAG_W'(1) << rfps_pkg::F_CHOKED;
   localparam logic [rfps_pkg::FLAG_W-1:0] FLAGS_OPEN =
      FLAGS_CLOSED | (rfps_pkg::FLAG_W'(1) << rfps_pkg::F_OPEN);

   assign rpi = req_ff.peer[rfps_pkg::PEER_W-1:0];
   assign psi = ps_ff[rfps_pkg::PEER_W-1:0];

   // Pieces in use: zero acts as one, anything above the table acts as full.
   always_comb begin
      if (csr_ff == '0) begin
         n_eff = rfps_pkg::CNT_W'(1);
      end else if (32'(csr_ff) > rfps_pkg::MAX_PIECES) begin
         n_eff = rfps_pkg::CNT_W'(rfps_pkg::MAX_PIECES);
      end else begin
         n_eff = rfps_pkg::CNT_W'(csr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= rfps_pkg::CSR_W'(256);
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // Scan engine: one table word read per cycle, evaluated in the next cycle.
   assign limit = (mode_ff == rfps_pkg::SCAN_INIT || mode_ff == rfps_pkg::SCAN_CLR) ?
                  rfps_pkg::CNT_W'(rfps_pkg::MAX_PIECES) : n_eff;
   assign issue  = active_ff && (addr_ff < limit);
   assign is_new = (rdata_ff.status == rfps_pkg::ST_NEW);
   assign is_tie = is_new && ({1'b0, rdata_ff.hold} == best_ff);

   always_comb begin
      found_now = 1'b0;
      if (active_ff && vld_ff) begin
         if (mode_ff == rfps_pkg::SCAN_PICK) begin
            found_now = is_tie && (k_ff == '0);
         end else if (mode_ff == rfps_pkg::SCAN_MORE) begin
            found_now = is_new && rdata_ff.has[rpi];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
         found_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         active_ff <= 1'b1;
         mode_ff   <= cmd.scan_mode;
         addr_ff   <= '0;
         vld_ff    <= 1'b0;
         found_ff  <= 1'b0;
         if (cmd.scan_mode == rfps_pkg::SCAN_MIN) begin
            best_ff <= BEST_NONE;
         end
         if (cmd.scan_mode == rfps_pkg::SCAN_CNT) begin
            ties_ff <= '0;
         end
         if (cmd.scan_mode == rfps_pkg::SCAN_PICK) begin
            k_ff <= rem_ff;
         end
      end else if (active_ff) begin
         if (issue) begin
            addr_ff <= addr_ff + rfps_pkg::CNT_W'(1);
         end
         vld_ff <= issue;
         idx_ff <= addr_ff[rfps_pkg::PIECE_W-1:0];
         if (vld_ff) begin
            unique case (mode_ff)
               rfps_pkg::SCAN_MIN: begin
                  if (is_new && ({1'b0, rdata_ff.hold} < best_ff)) begin
                     best_ff <= {1'b0, rdata_ff.hold};
                  end
               end
               rfps_pkg::SCAN_CNT: begin
                  if (is_tie) begin
                     ties_ff <= ties_ff + rfps_pkg::CNT_W'(1);
                  end
               end
               rfps_pkg::SCAN_PICK: begin
                  if (is_tie) begin
                     if (k_ff == '0) begin
                        chosen_ff   <= idx_ff;
                        chosen_e_ff <= rdata_ff;
                     end else begin
                        k_ff <= k_ff - rfps_pkg::CNT_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (found_now) begin
            active_ff <= 1'b0;
            vld_ff    <= 1'b0;
            found_ff  <= 1'b1;
         end else if (!issue && !vld_ff) begin
            active_ff <= 1'b0;
         end
      end
   end

   // Piece table port selection.
   assign rd_en   = cmd.rd_piece || (issue && mode_ff != rfps_pkg::SCAN_INIT);
   assign rd_addr = cmd.rd_piece ? rfps_pkg::PIECE_W'(req_ff.piece) :
                                   addr_ff[rfps_pkg::PIECE_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rdata_ff;
      if (issue && mode_ff == rfps_pkg::SCAN_INIT) begin
         wr_en   = 1'b1;
         wr_addr = addr_ff[rfps_pkg::PIECE_W-1:0];
         wr_data = '0;
      end else if (active_ff && vld_ff && mode_ff == rfps_pkg::SCAN_CLR) begin
         wr_en            = 1'b1;
         wr_data.has[rpi] = 1'b0;
      end else begin
         unique case (cmd.wr_sel)
            rfps_pkg::WR_HAVE: begin
               wr_en            = 1'b1;
               wr_addr          = rfps_pkg::PIECE_W'(req_ff.piece);
               wr_data.has[rpi] = 1'b1;
               if (rdata_ff.hold != HOLD_SAT) begin
                  wr_data.hold = rdata_ff.hold + rfps_pkg::HOLD_W'(1);
               end
            end
            rfps_pkg::WR_DONE: begin
               wr_en          = 1'b1;
               wr_addr        = rfps_pkg::PIECE_W'(req_ff.piece);
               wr_data.status = rfps_pkg::ST_DONE;
            end
            rfps_pkg::WR_LOAD: begin
               wr_en          = 1'b1;
               wr_addr        = chosen_ff;
               wr_data        = chosen_e_ff;
               wr_data.status = rfps_pkg::ST_LOADING;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         piece_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= piece_mem_ff[rd_addr];
      end
   end

   // Restoring divider: one quotient bit per cycle, only the remainder is kept.
   assign trial = {rem_ff, dvd_ff[rfps_pkg::RND_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         rem_ff  <= '0;
         dvd_ff  <= req_ff.random_value;
         dcnt_ff <= rfps_pkg::DIV_CNT_W'(rfps_pkg::RND_W);
      end else if (dcnt_ff != '0) begin
         if (trial >= {1'b0, ties_ff}) begin
            rem_ff <= rfps_pkg::CNT_W'(trial - {1'b0, ties_ff});
         end else begin
            rem_ff <= trial[rfps_pkg::CNT_W-1:0];
         end
         dvd_ff  <= {dvd_ff[rfps_pkg::RND_W-2:0], 1'b0};
         dcnt_ff <= dcnt_ff - rfps_pkg::DIV_CNT_W'(1);
      end
   end

   // Peer flags, wanted pieces and the peer walk of a select.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rfps_pkg::NUM_PEERS; i++) begin
            flags_ff[i]  <= FLAGS_CLOSED;
            wanted_ff[i] <= '0;
         end
      end else begin
         if (cmd.peer_init) begin
            flags_ff[rpi]  <= cmd.peer_init_open ? FLAGS_OPEN : FLAGS_CLOSED;
            wanted_ff[rpi] <= '0;
         end
         if (cmd.set_choke) begin
            flags_ff[rpi][rfps_pkg::F_CHOKED] <= 1'b1;
         end
         if (cmd.clr_choke) begin
            flags_ff[rpi][rfps_pkg::F_CHOKED] <= 1'b0;
         end
         if (cmd.set_int_req) begin
            flags_ff[rpi][rfps_pkg::F_INTEREST] <= 1'b1;
         end
         if (cmd.clr_int_req) begin
            flags_ff[rpi][rfps_pkg::F_INTEREST] <= 1'b0;
         end
         if (cmd.clr_busy_req) begin
            flags_ff[rpi][rfps_pkg::F_BUSY] <= 1'b0;
         end
         if (cmd.ps_set_int) begin
            flags_ff[psi][rfps_pkg::F_INTEREST] <= 1'b1;
         end
         if (cmd.ps_set_req) begin
            flags_ff[psi][rfps_pkg::F_INTEREST] <= 1'b1;
            flags_ff[psi][rfps_pkg::F_BUSY]     <= 1'b1;
            wanted_ff[psi]                      <= chosen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ps_start) begin
         ps_ff <= '0;
      end else if (cmd.ps_next) begin
         ps_ff <= ps_ff + (rfps_pkg::PEER_W + 1)'(1);
      end
   end

   // Result stage.
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.action = cmd.emit_action;
      rsp_data_in.last   = (cmd.emit_action == rfps_pkg::ACT_END);
      if (cmd.emit_action != rfps_pkg::ACT_END) begin
         rsp_data_in.target_peer = cmd.emit_scan_peer ? 3'(psi) : req_ff.peer;
      end
      if (cmd.emit_action == rfps_pkg::ACT_REQ) begin
         rsp_data_in.target_piece = 8'(chosen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status back to the controller.
   always_comb begin
      sts            = '0;
      sts.op         = req_ff.opcode;
      sts.scan_busy  = active_ff;
      sts.scan_found = found_ff;
      sts.best_none  = (best_ff == BEST_NONE);
      sts.div_busy   = (dcnt_ff != '0);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.req_open   = flags_ff[rpi][rfps_pkg::F_OPEN];
      sts.req_int    = flags_ff[rpi][rfps_pkg::F_INTEREST];
      sts.req_match  = flags_ff[rpi][rfps_pkg::F_BUSY] &&
                       (wanted_ff[rpi] == rfps_pkg::PIECE_W'(req_ff.piece));
      sts.piece_ok   = ({1'b0, req_ff.piece} < 9'(n_eff));
      sts.entry_new  = is_new;
      sts.ps_end     = (ps_ff == (rfps_pkg::PEER_W + 1)'(rfps_pkg::NUM_PEERS));
      sts.ps_cand    = flags_ff[psi][rfps_pkg::F_OPEN] && chosen_e_ff.has[psi];
      sts.ps_choked  = flags_ff[psi][rfps_pkg::F_CHOKED];
      sts.ps_int     = flags_ff[psi][rfps_pkg::F_INTEREST];
      sts.ps_busy    = flags_ff[psi][rfps_pkg::F_BUSY];
   end

endmodule

// ----- hdl/rfps_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfps_ctrl: sequencing state machine of the scheduler
// Decodes one event at a time and steps the datapath through its phases.
// ----------------------------------------------------------------------------
module rfps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output rfps_pkg::cmd_type cmd,
   input  rfps_pkg::sts_type sts
);

   typedef enum logic [4:0] {
      S_INIT,
      S_INIT_WAIT,
      S_IDLE,
      S_DECODE,
      S_HAVE_WR,
      S_HAVE_INT,
      S_DONE_WR,
      S_MORE,
      S_CLR,
      S_SEL,
      S_MIN,
      S_CNT,
      S_DIV,
      S_PICK,
      S_PEER,
      S_END
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = rfps_pkg::SCAN_INIT;
            state_in       = S_INIT_WAIT;
         end
         S_INIT_WAIT: begin
            if (!sts.scan_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               rfps_pkg::OP_HAVE: begin
                  if (sts.req_open && sts.piece_ok) begin
                     cmd.rd_piece = 1'b1;
                     state_in     = S_HAVE_WR;
                  end else begin
                     state_in = S_END;
                  end
               end
               rfps_pkg::OP_CHOKE: begin
                  cmd.set_choke = sts.req_open;
                  state_in      = S_END;
               end
               rfps_pkg::OP_UNCHOKE: begin
                  cmd.clr_choke = sts.req_open;
                  state_in      = (sts.req_open && sts.req_int) ? S_SEL : S_END;
               end
               rfps_pkg::OP_DONE: begin
                  if (sts.req_open && sts.req_match) begin
                     cmd.rd_piece = 1'b1;
                     state_in     = S_DONE_WR;
                  end else begin
                     cmd.peer_init  = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode  = rfps_pkg::SCAN_CLR;
                     state_in       = S_CLR;
                  end
               end
               rfps_pkg::OP_SELECT: begin
                  state_in = S_SEL;
               end
               rfps_pkg::OP_OPEN, rfps_pkg::OP_CLOSE: begin
                  cmd.peer_init      = 1'b1;
                  cmd.peer_init_open = (sts.op == rfps_pkg::OP_OPEN);
                  cmd.scan_start     = 1'b1;
                  cmd.scan_mode      = rfps_pkg::SCAN_CLR;
                  state_in           = S_CLR;
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_HAVE_WR: begin
            cmd.wr_sel = rfps_pkg::WR_HAVE;
            state_in   = sts.entry_new ? S_HAVE_INT : S_END;
         end
         S_HAVE_INT: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_action = rfps_pkg::ACT_INT;
               cmd.set_int_req = 1'b1;
               state_in        = S_SEL;
            end
         end
         S_DONE_WR: begin
            cmd.wr_sel       = rfps_pkg::WR_DONE;
            cmd.clr_busy_req = 1'b1;
            cmd.scan_start   = 1'b1;
            cmd.scan_mode    = rfps_pkg::SCAN_MORE;
            state_in         = S_MORE;
         end
         S_MORE: begin
            if (!sts.scan_busy) begin
               if (sts.scan_found) begin
                  cmd.set_int_req = 1'b1;
                  state_in        = S_SEL;
               end else begin
                  cmd.clr_int_req = 1'b1;
                  state_in        = S_END;
               end
            end
         end
         S_CLR: begin
            if (!sts.scan_busy) begin
               state_in = S_END;
            end
         end
         S_SEL: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = rfps_pkg::SCAN_MIN;
            state_in       = S_MIN;
         end
         S_MIN: begin
            if (!sts.scan_busy) begin
               if (sts.best_none) begin
                  state_in = S_END;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_mode  = rfps_pkg::SCAN_CNT;
                  state_in       = S_CNT;
               end
            end
         end
         S_CNT: begin
            if (!sts.scan_busy) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = rfps_pkg::SCAN_PICK;
               state_in       = S_PICK;
            end
         end
         S_PICK: begin
            if (!sts.scan_busy) begin
               cmd.ps_start = 1'b1;
               state_in     = S_PEER;
            end
         end
         S_PEER: begin
            cmd.emit_scan_peer = 1'b1;
            priority if (sts.ps_end) begin
               state_in = S_END;
            end else if (!sts.ps_cand) begin
               cmd.ps_next = 1'b1;
            end else if (sts.ps_choked) begin
               if (sts.ps_int) begin
                  cmd.ps_next = 1'b1;
               end else if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_action = rfps_pkg::ACT_INT;
                  cmd.ps_set_int  = 1'b1;
                  cmd.ps_next     = 1'b1;
               end
            end else if (sts.ps_busy) begin
               cmd.ps_next = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (!sts.ps_int) begin
                  // Interested goes first; the request for this peer follows once the result register is free.
                  cmd.emit_action = rfps_pkg::ACT_INT;
                  cmd.ps_set_int  = 1'b1;
               end else begin
                  cmd.emit_action = rfps_pkg::ACT_REQ;
                  cmd.ps_set_req  = 1'b1;
                  cmd.wr_sel      = rfps_pkg::WR_LOAD;
                  state_in        = S_END;
               end
            end else begin
               // The result register is still full; the same peer is retried.
            end
         end
         S_END: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_action = rfps_pkg::ACT_END;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// ----- hdl/rarest_first_piece_scheduler.sv -----
// ----------------------------------------------------------------------------
// rarest_first_piece_scheduler: rarest-first piece selection for a download
// Tracks piece holders and peer state and answers each event with a run of
// interested and request messages closed by an end beat.
// ----------------------------------------------------------------------------
// Choke and ignored events go straight to the end beat; a valid have reads and
// writes its table word; a matching piece done runs a search pass over the
// pieces in use; peer open, close and a failed piece done clear the peer's bits in all words.
// A select adds a minimum pass, a tie-count pass, the remainder division, a
// pick pass and the peer walk. The next event is taken in the cycle after the
// end beat is issued; after the synchronous reset a clearing pass stalls the input.
// ----------------------------------------------------------------------------
module rarest_first_piece_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rfps_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rfps_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [rfps_pkg::CSR_W-1:0] csr_wdata
);

   // The controller sequences each event; the datapath owns the piece table,
   // which keeps holder count, status and all peers' holder bits per word, so
   // one read tells which peers hold the chosen piece.
   rfps_pkg::cmd_type cmd;
   rfps_pkg::sts_type sts;

   rfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The result register lets the controller keep working while a beat
   // waits on the output stall.
   rfps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/rfps_checker.sv -----
// ----------------------------------------------------------------------------
// rfps_checker: port-level checks of the scheduler
// Watches the result channel and the input stall after reset.
// ----------------------------------------------------------------------------
module rfps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rfps_pkg::rsp_type rsp_data
);

   // A stalled result beat stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // Only the end beat closes a run.
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.action == rfps_pkg::ACT_END)))
      else $error("last does not match the end action");

   // Only a request names a piece.
   a_piece_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != rfps_pkg::ACT_REQ |-> rsp_data.target_piece == '0)
      else $error("piece given on a non-request beat");

   // The table clearing pass keeps the input stalled right after reset.
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken during the clearing pass");

endmodule

bind rarest_first_piece_scheduler rfps_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/rarest_first_piece_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarest_first_piece_scheduler_tb: self-checking bench for the piece scheduler
// Sends peer events to the block, predicts each message run from its own
// model of piece and peer state, and compares every result beat in order.
// ----------------------------------------------------------------------------
module rarest_first_piece_scheduler_tb;

   // The scheduler model. It keeps its own copy of the piece table, the peer
   // flags and the piece count, and holds the messages still due.
   class sched_model;
      logic [7:0] holders [rfps_pkg::MAX_PIECES];
      logic [1:0] status [rfps_pkg::MAX_PIECES];
      bit         has [rfps_pkg::NUM_PEERS][rfps_pkg::MAX_PIECES];
      bit         is_open [rfps_pkg::NUM_PEERS];
      bit         choked [rfps_pkg::NUM_PEERS];
      bit         interest [rfps_pkg::NUM_PEERS];
      bit         busy [rfps_pkg::NUM_PEERS];
      logic [7:0] wanted [rfps_pkg::NUM_PEERS];
      int unsigned pieces;
      rfps_pkg::rsp_type due_msgs [$];
      int         errors;

      function new();
         pieces = 256;
         errors = 0;
         foreach (holders[i]) begin
            holders[i] = 0;
            status[i] = rfps_pkg::ST_NEW;
         end
         for (int p = 0; p < rfps_pkg::NUM_PEERS; p++) begin
            clear_peer(p, 1'b0);
         end
      endfunction

      function void set_piece_count(logic [8:0] v);
         pieces = (v == 0) ? 1 : (v > rfps_pkg::MAX_PIECES ? rfps_pkg::MAX_PIECES : v);
      endfunction

      function void clear_peer(int p, bit opn);
         is_open[p] = opn;
         choked[p] = 1;
         interest[p] = 0;
         busy[p] = 0;
         wanted[p] = 0;
         for (int i = 0; i < rfps_pkg::MAX_PIECES; i++) begin
            has[p][i] = 0;
         end
      endfunction

      function void push_msg(logic [1:0] act, int p, int pc, bit lst);
         rfps_pkg::rsp_type r;
         r.action = act;
         r.target_peer = p[2:0];
         r.target_piece = pc[7:0];
         r.last = lst;
         due_msgs.push_back(r);
      endfunction

      // Rarest-first choice followed by the peer walk; stops after one request.
      function void pick_rarest(logic [15:0] rnd);
         int best, ties, k, chosen;
         best = 256;
         ties = 0;
         chosen = 0;
         for (int i = 0; i < pieces; i++) begin
            if (status[i] == rfps_pkg::ST_NEW && holders[i] < best) best = holders[i];
         end
         if (best == 256) return;
         for (int i = 0; i < pieces; i++) begin
            if (status[i] == rfps_pkg::ST_NEW && holders[i] == best) ties++;
         end
         k = rnd % ties;
         for (int i = 0; i < pieces; i++) begin
            if (status[i] == rfps_pkg::ST_NEW && holders[i] == best) begin
               if (k == 0) begin
                  chosen = i;
                  break;
               end
               k--;
            end
         end
         for (int p = 0; p < rfps_pkg::NUM_PEERS; p++) begin
            if (!is_open[p] || !has[p][chosen]) continue;
            if (choked[p]) begin
               if (!interest[p]) begin
                  push_msg(rfps_pkg::ACT_INT, p, 0, 0);
                  interest[p] = 1;
               end
            end else if (!busy[p]) begin
               if (!interest[p]) push_msg(rfps_pkg::ACT_INT, p, 0, 0);
               push_msg(rfps_pkg::ACT_REQ, p, chosen, 0);
               interest[p] = 1;
               busy[p] = 1;
               wanted[p] = chosen[7:0];
               status[chosen] = rfps_pkg::ST_LOADING;
               return;
            end
         end
      endfunction

      // Notes one accepted input beat and queues the messages it causes.
      function void note_event(rfps_pkg::req_type rq);
         int p, pc;
         bit more;
         p = rq.peer;
         pc = rq.piece;
         case (rq.opcode)
            rfps_pkg::OP_HAVE: begin
               if (is_open[p] && pc < pieces) begin
                  has[p][pc] = 1;
                  if (holders[pc] != 8'hFF) holders[pc]++;
                  if (status[pc] == rfps_pkg::ST_NEW) begin
                     push_msg(rfps_pkg::ACT_INT, p, 0, 0);
                     interest[p] = 1;
                     pick_rarest(rq.random_value);
                  end
               end
            end
            rfps_pkg::OP_CHOKE: begin
               if (is_open[p]) choked[p] = 1;
            end
            rfps_pkg::OP_UNCHOKE: begin
               if (is_open[p]) begin
                  choked[p] = 0;
                  if (interest[p]) pick_rarest(rq.random_value);
               end
            end
            rfps_pkg::OP_DONE: begin
               if (is_open[p] && busy[p] && wanted[p] == pc[7:0]) begin
                  more = 0;
                  busy[p] = 0;
                  status[pc] = rfps_pkg::ST_DONE;
                  for (int i = 0; i < pieces; i++) begin
                     if (status[i] == rfps_pkg::ST_NEW && has[p][i]) begin
                        more = 1;
                        break;
                     end
                  end
                  interest[p] = more;
                  if (more) pick_rarest(rq.random_value);
               end else begin
                  clear_peer(p, 0);
               end
            end
            rfps_pkg::OP_SELECT: pick_rarest(rq.random_value);
            rfps_pkg::OP_OPEN: clear_peer(p, 1);
            rfps_pkg::OP_CLOSE: clear_peer(p, 0);
            default: ;
         endcase
         push_msg(rfps_pkg::ACT_END, 0, 0, 1);
      endfunction

      function void check_msg(rfps_pkg::rsp_type got);
         rfps_pkg::rsp_type exp;
         if (due_msgs.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            errors++;
            return;
         end
         exp = due_msgs.pop_front();
         if (got.action !== exp.action) begin
            $error("action: expected %0d, got %0d", exp.action, got.action);
            errors++;
         end
         if (got.target_peer !== exp.target_peer) begin
            $error("target_peer: expected %0d, got %0d", exp.target_peer, got.target_peer);
            errors++;
         end
         if (got.target_piece !== exp.target_piece) begin
            $error("target_piece: expected %0d, got %0d", exp.target_piece,
                   got.target_piece);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 40000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   rfps_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rfps_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [8:0]        csr_wdata;

   sched_model model;
   int  send_idle_pct;   // chance in percent that the sender skips a cycle
   int  recv_stall_pct;  // chance in percent that the receiver stalls
   bit  hold_off;        // long receiver hold-off, set by the stimulus
   int  quiet_cycles;

   rarest_first_piece_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver side: the stall pattern is redrawn at each falling edge, and
   // every beat that is taken at the rising edge goes to the scoreboard.
   initial begin
      rsp_stall = 1;
      forever begin
         @(negedge clock);
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) model.check_msg(rsp_data);
   end

   // The watchdog counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offers one event, holding it steady until a beat is accepted. Valid
   // stays high across back-to-back events so it is never dropped and
   // raised within one step.
   task automatic send_event(logic [2:0] op, int p, int pc, logic [15:0] rnd);
      rfps_pkg::req_type rq;
      rq.opcode = op;
      rq.peer = p[2:0];
      rq.piece = pc[7:0];
      rq.random_value = rnd;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.note_event(rq);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 0;
      while (model.due_msgs.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_piece_count(logic [8:0] v);
      quiesce();
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      model.set_piece_count(v);
   endtask

   // A random event, biased toward well-formed traffic: haves and unchokes on
   // open peers, matching piece-done beats for outstanding requests.
   task automatic random_event();
      int p, r, pc;
      p = $urandom_range(rfps_pkg::NUM_PEERS - 1);
      r = $urandom_range(99);
      pc = $urandom_range(model.pieces - 1);
      if (!model.is_open[p] && r < 70) begin
         send_event(rfps_pkg::OP_OPEN, p, $urandom_range(255), 16'($urandom));
      end else if (model.busy[p] && r < 35) begin
         send_event(rfps_pkg::OP_DONE, p, model.wanted[p], 16'($urandom));
      end else if (r < 55) begin
         send_event(rfps_pkg::OP_HAVE, p, (r < 52) ? pc : $urandom_range(255),
                    16'($urandom));
      end else if (r < 67) begin
         send_event(rfps_pkg::OP_UNCHOKE, p, $urandom_range(255), 16'($urandom));
      end else if (r < 74) begin
         send_event(rfps_pkg::OP_CHOKE, p, $urandom_range(255), 16'($urandom));
      end else if (r < 84) begin
         send_event(rfps_pkg::OP_SELECT, p, $urandom_range(255), 16'($urandom));
      end else if (r < 89) begin
         send_event(rfps_pkg::OP_DONE, p, $urandom_range(255), 16'($urandom));
      end else if (r < 93) begin
         send_event(rfps_pkg::OP_CLOSE, p, $urandom_range(255), 16'($urandom));
      end else if (r < 97) begin
         send_event(rfps_pkg::OP_OPEN, p, $urandom_range(255), 16'($urandom));
      end else begin
         send_event(rfps_pkg::OP_NOP, p, $urandom_range(255), 16'($urandom));
      end
   endtask

   initial begin
      model = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_wdata = '0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part with a tiny table, so ties, saturation and the
      // no-piece-left case are reached quickly.
      write_piece_count(9'd4);
      send_event(rfps_pkg::OP_HAVE, 0, 0, 16'h0);     // have on a closed peer is ignored
      send_event(rfps_pkg::OP_OPEN, 0, 0, 16'h0);
      send_event(rfps_pkg::OP_OPEN, 7, 255, 16'hFFFF);
      send_event(rfps_pkg::OP_HAVE, 0, 2, 16'hFFFF);  // interested, choked peer
      send_event(rfps_pkg::OP_HAVE, 0, 200, 16'h0);   // piece beyond the count
      send_event(rfps_pkg::OP_UNCHOKE, 0, 0, 16'h1);  // rarest pieces have no holder: no request
      send_event(rfps_pkg::OP_HAVE, 7, 2, 16'h5);
      send_event(rfps_pkg::OP_DONE, 0, 2, 16'h0);     // no request outstanding: closes the peer
      send_event(rfps_pkg::OP_CHOKE, 7, 0, 16'h0);
      send_event(rfps_pkg::OP_DONE, 7, 3, 16'h0);     // unmatched piece done closes the peer
      send_event(rfps_pkg::OP_SELECT, 3, 0, 16'hFFFF);
      send_event(rfps_pkg::OP_NOP, 5, 0, 16'h0);
      send_event(rfps_pkg::OP_CLOSE, 0, 0, 16'h0);
      for (int i = 0; i < 4; i++) begin
         send_event(rfps_pkg::OP_OPEN, i, 0, 16'h0);
         send_event(rfps_pkg::OP_UNCHOKE, i, 0, 16'h0);
         for (int j = 0; j < 4; j++) begin
            send_event(rfps_pkg::OP_HAVE, i, j, 16'(16'hFFFF - j));
         end
      end
      for (int i = 0; i < 4; i++) send_event(rfps_pkg::OP_DONE, i, model.wanted[i], 16'h0);
      send_event(rfps_pkg::OP_SELECT, 1, 0, 16'h0);   // nothing left may be chosen
      write_piece_count(9'd1);
      send_event(rfps_pkg::OP_OPEN, 4, 0, 16'h0);
      repeat (260) send_event(rfps_pkg::OP_HAVE, 4, 0, 16'($urandom));  // count saturates
      write_piece_count(9'd0);
      send_event(rfps_pkg::OP_SELECT, 4, 0, 16'h0);

      // Random phases through several piece counts and idling styles.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         case (ph)
            0: write_piece_count(9'd8);
            3: write_piece_count(9'd256);
            5: write_piece_count(9'd511);
            7: write_piece_count(9'd3);
            default: write_piece_count(9'($urandom_range(2, 24)));
         endcase
         if (ph == 4) begin
            // Hold off the receiver while events keep coming, so the block
            // backs up and stalls its input.
            fork
               begin
                  hold_off = 1;
                  repeat (600) @(negedge clock);
                  hold_off = 0;
               end
               repeat (10) random_event();
            join
         end
         repeat (11) random_event();
         quiesce();  // sender pause until every message has arrived
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiesce();
      if (model.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- rarest_first_piece_scheduler.f -----
hdl/rfps_pkg.sv
hdl/rfps_datapath.sv
hdl/rfps_ctrl.sv
hdl/rarest_first_piece_scheduler.sv
hdl/rfps_checker.sv
dv/rarest_first_piece_scheduler_tb.sv
